/* rtl/assert_macros.svh */
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");

`define CHK_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");

`endif

/* rtl/rrtns_pkg.sv */
package rrtns_pkg;
  localparam int MAX_NODES_DEF  = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int CUT_W = 34;
  localparam logic [CUT_W-1:0] CUTOFF_RESET = 34'd12884508675;

  typedef enum logic [2:0] {
    MD_ADD = 3'd0, MD_REMOVE = 3'd1, MD_READ = 3'd2, MD_SETPOS = 3'd3,
    MD_SETPAR = 3'd4, MD_NEAREST = 3'd5, MD_PATH = 3'd6, MD_CLEAR = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_FULL = 3'd1, ST_BADIDX = 3'd2, ST_NONE = 3'd3, ST_CYCLE = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_REMOVE, S_NEAR, S_NEAR_END, S_WALK, S_WALK_CHK, S_EMIT_RD,
    S_EMIT
  } state_t;
endpackage

/* rtl/rrtns_dist.sv */
module rrtns_dist
  import rrtns_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  input  logic signed [COORD_BITS-1:0] qz,
  input  logic signed [COORD_BITS-1:0] sx,
  input  logic signed [COORD_BITS-1:0] sy,
  input  logic signed [COORD_BITS-1:0] sz,
  output logic [2*COORD_BITS+1:0]      sq_dist
);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS;
  logic [DW-1:0] ax, ay, az;
  logic [PW-1:0] px_r, py_r, pz_r;

  function automatic logic [DW-1:0] absd(input logic signed [COORD_BITS-1:0] a,
                                         input logic signed [COORD_BITS-1:0] b);
    logic signed [DW-1:0] d;
    d = DW'(a) - DW'(b);
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  always_comb begin
    ax = absd(qx, sx);
    ay = absd(qy, sy);
    az = absd(qz, sz);
  end

  always_ff @(posedge clk) begin
    px_r <= PW'(ax * ax);
    py_r <= PW'(ay * ay);
    pz_r <= PW'(az * az);
  end

  assign sq_dist = (PW+2)'(px_r) + (PW+2)'(py_r) + (PW+2)'(pz_r);
endmodule

/* rtl/rrt_node_store_nearest_search.sv */
// Add, clear and bad-index items answer straight from idle; read and set answer after a
// memory read; remove shifts the entries above the index down; nearest scans every stored entry.
// Path: walks the parent links node by node, then one result per cycle, root first.
// Next item accepted in the cycle the last result shows; memory scanned one entry per cycle.
// Synchronous active-low reset: count=1, root at origin, cutoff reset value.
// Results carry out_valid for one cycle; the receiver cannot stall.
module rrt_node_store_nearest_search
  import rrtns_pkg::*;
#(
  parameter int MAX_NODES  = MAX_NODES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_mode,
  input  logic [5:0]                   in_node_index,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_pos_z,
  input  logic [5:0]                   in_parent_index,
  input  logic [5:0]                   in_node_label,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CUT_W-1:0]             cfg_cutoff_sq,
  output logic                         out_valid,
  output logic [2:0]                   out_status,
  output logic [5:0]                   out_result_index,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z,
  output logic [5:0]                   out_parent,
  output logic [5:0]                   out_label,
  output logic [6:0]                   out_node_count,
  output logic                         out_last
);
  `include "assert_macros.svh"

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int EW = 3 * COORD_BITS + 12;
  localparam int DSW = 2 * COORD_BITS + 2;
  localparam int CMPW = (DSW > CUT_W) ? DSW : CUT_W;

  // node memory: {x,y,z,parent,label}; path stack memory
  logic [EW-1:0] node_mem [MAX_NODES];
  logic [AW-1:0] stk_mem  [MAX_NODES];

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CUT_W-1:0] cut_r;
  logic [2:0] mode_r;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic signed [COORD_BITS-1:0] qx_r, qy_r, qz_r;
  logic [5:0] qpar_r, qlab_r;
  logic [CUT_W-1:0] best_r, best_nxt;
  logic [AW-1:0] bi_r, bi_nxt;
  logic found_r, found_nxt;
  logic [AW-1:0] scan_r, scan_nxt;
  logic [AW-1:0] cidx_r, cidx_nxt;
  logic cv_r, cv_nxt;

  logic rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data_r;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_d;
  logic stk_we;
  logic [AW-1:0] stk_wa, stk_ra;
  logic [AW-1:0] stk_data_r;

  logic ov_nxt;
  logic [2:0] os_nxt;
  logic [5:0] oi_nxt, op_nxt, ol_nxt;
  logic signed [COORD_BITS-1:0] ox_nxt, oy_nxt, oz_nxt;
  logic olast_nxt;
  logic [DSW-1:0] sq_dist;
  logic seed_r;

  always_ff @(posedge clk) begin
    if (wr_en) node_mem[wr_addr] <= wr_d;
    if (rd_en) rd_data_r <= node_mem[rd_addr];
    if (stk_we) stk_mem[stk_wa] <= idx_r;
    stk_data_r <= stk_mem[stk_ra];
  end

  logic signed [COORD_BITS-1:0] mx, my, mz;
  logic [5:0] mpar, mlab;
  assign {mx, my, mz, mpar, mlab} = rd_data_r;

  rrtns_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk(clk), .qx(qx_r), .qy(qy_r), .qz(qz_r), .sx(mx), .sy(my), .sz(mz),
    .sq_dist(sq_dist)
  );

  assign busy = (state_r != S_IDLE) || seed_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    len_nxt = len_r;
    best_nxt = best_r;
    bi_nxt = bi_r;
    found_nxt = found_r;
    scan_nxt = scan_r;
    cidx_nxt = cidx_r;
    cv_nxt = 1'b0;
    rd_en = 1'b0;
    rd_addr = idx_r;
    wr_en = seed_r;
    wr_addr = '0;
    wr_d = '0;
    stk_we = 1'b0;
    stk_wa = len_r[AW-1:0];
    stk_ra = idx_r;
    ov_nxt = 1'b0;
    os_nxt = ST_OK;
    oi_nxt = '0;
    ox_nxt = '0;
    oy_nxt = '0;
    oz_nxt = '0;
    op_nxt = '0;
    ol_nxt = '0;
    olast_nxt = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (start && !seed_r) begin
          idx_nxt = AW'(in_node_index);
          case (mode_t'(in_mode))
            MD_ADD: begin
              ov_nxt = 1'b1;
              if (count_r >= CW'(MAX_NODES)) begin
                os_nxt = ST_FULL;
              end else begin
                wr_en = 1'b1;
                wr_addr = count_r[AW-1:0];
                wr_d = {in_pos_x, in_pos_y, in_pos_z, in_parent_index, in_node_label};
                oi_nxt = 6'(count_r);
                count_nxt = count_r + 1'b1;
              end
            end
            MD_CLEAR: begin
              ov_nxt = 1'b1;
              wr_en = 1'b1;
              wr_d = {in_pos_x, in_pos_y, in_pos_z, 12'd0};
              count_nxt = CW'(1);
            end
            MD_NEAREST: begin
              best_nxt = cut_r;
              bi_nxt = '0;
              found_nxt = 1'b0;
              scan_nxt = '0;
              if (count_r == '0) begin
                ov_nxt = 1'b1;
                os_nxt = ST_NONE;
              end else begin
                rd_en = 1'b1;
                rd_addr = '0;
                state_nxt = S_NEAR;
                cidx_nxt = '0;
              end
            end
            default: begin
              if ({1'b0, in_node_index} >= 7'(count_r)) begin
                ov_nxt = 1'b1;
                os_nxt = ST_BADIDX;
              end else if (mode_t'(in_mode) == MD_SETPAR ||
                           mode_t'(in_mode) == MD_SETPOS) begin
                rd_en = 1'b1;
                rd_addr = AW'(in_node_index);
                state_nxt = S_READ;
              end else if (mode_t'(in_mode) == MD_REMOVE) begin
                rd_en = 1'b1;
                rd_addr = AW'(in_node_index);
                scan_nxt = AW'(in_node_index);
                state_nxt = S_REMOVE;
              end else if (mode_t'(in_mode) == MD_READ) begin
                rd_en = 1'b1;
                rd_addr = AW'(in_node_index);
                state_nxt = S_EMIT_RD;
              end else begin
                rd_en = 1'b1;
                rd_addr = AW'(in_node_index);
                len_nxt = '0;
                state_nxt = S_WALK;
              end
            end
          endcase
        end
      end
      S_READ: begin
        // read-modify-write for set position / set parent
        wr_en = 1'b1;
        wr_addr = idx_r;
        if (mode_t'(mode_r) == MD_SETPOS) wr_d = {qx_r, qy_r, qz_r, mpar, mlab};
        else wr_d = {mx, my, mz, qpar_r, mlab};
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_EMIT_RD: begin
        ov_nxt = 1'b1;
        ox_nxt = mx; oy_nxt = my; oz_nxt = mz; op_nxt = mpar; ol_nxt = mlab;
        state_nxt = S_IDLE;
      end
      S_REMOVE: begin
        // first cycle: read data holds removed node; later: shift entry scan+1 to scan
        if (cv_r) begin
          wr_en = 1'b1;
          wr_addr = scan_r;
          wr_d = rd_data_r;
          scan_nxt = scan_r + 1'b1;
        end
        if (CW'(scan_r) + CW'(cv_r) + 1'b1 >= count_r) begin
          ov_nxt = 1'b1;
          if (cv_r) begin
            ox_nxt = qx_r; oy_nxt = qy_r; oz_nxt = qz_r; op_nxt = qpar_r; ol_nxt = qlab_r;
          end else begin
            ox_nxt = mx; oy_nxt = my; oz_nxt = mz; op_nxt = mpar; ol_nxt = mlab;
          end
          count_nxt = count_r - 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rd_en = 1'b1;
          rd_addr = AW'(CW'(scan_r) + CW'(cv_r) + 1'b1);
          cv_nxt = 1'b1;
        end
      end
      S_NEAR: begin
        // pipeline: read at cidx, then rd_data_r register, then squares registered in u_dist
        if (CW'(cidx_r) + 1'b1 < count_r) begin
          rd_en = 1'b1;
          rd_addr = cidx_r + 1'b1;
          cidx_nxt = cidx_r + 1'b1;
        end else begin
          state_nxt = S_NEAR_END;
        end
        cv_nxt = 1'b1;
        if (cv_r) begin
          if (CMPW'(sq_dist) < CMPW'(best_r)) begin
            best_nxt = CUT_W'(sq_dist);
            bi_nxt = scan_r;
            found_nxt = 1'b1;
          end
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_NEAR_END: begin
        if (CMPW'(sq_dist) < CMPW'(best_r)) begin
          bi_nxt = scan_r;
          found_nxt = 1'b1;
        end
        ov_nxt = 1'b1;
        os_nxt = (found_nxt) ? ST_OK : ST_NONE;
        oi_nxt = 6'(bi_nxt);
        state_nxt = S_IDLE;
      end
      S_WALK: begin
        stk_we = 1'b1;
        len_nxt = len_r + 1'b1;
        if (mlab == '0) begin
          // root is being pushed now; first emit takes it from idx_r
          cv_nxt = 1'b1;
          state_nxt = S_EMIT;
        end else if ({1'b0, mpar} >= 7'(count_r)) begin
          ov_nxt = 1'b1;
          os_nxt = ST_BADIDX;
          state_nxt = S_IDLE;
        end else if (len_nxt >= count_r) begin
          ov_nxt = 1'b1;
          os_nxt = ST_CYCLE;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = AW'(mpar);
          rd_en = 1'b1;
          rd_addr = AW'(mpar);
          state_nxt = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        state_nxt = S_WALK;
      end
      S_EMIT: begin
        ov_nxt = 1'b1;
        oi_nxt = cv_r ? 6'(idx_r) : 6'(stk_data_r);
        olast_nxt = (len_r == CW'(1));
        len_nxt = len_r - 1'b1;
        stk_ra = AW'(len_r - CW'(2));
        if (len_r == CW'(1)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= CW'(1);
      cut_r <= CUTOFF_RESET;
      out_valid <= 1'b0;
      cv_r <= 1'b0;
      seed_r <= 1'b1;
    end else begin
      seed_r <= 1'b0;
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid <= ov_nxt;
      cv_r <= cv_nxt;
      if (cfg_valid && cfg_ready) cut_r <= cfg_cutoff_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start && !seed_r) begin
      mode_r <= in_mode;
      qx_r <= in_pos_x;
      qy_r <= in_pos_y;
      qz_r <= in_pos_z;
      qpar_r <= in_parent_index;
      qlab_r <= in_node_label;
    end else if (state_r == S_REMOVE && !cv_r) begin
      qx_r <= mx;
      qy_r <= my;
      qz_r <= mz;
      qpar_r <= mpar;
      qlab_r <= mlab;
    end
    idx_r <= idx_nxt;
    len_r <= len_nxt;
    best_r <= best_nxt;
    bi_r <= bi_nxt;
    found_r <= found_nxt;
    scan_r <= scan_nxt;
    cidx_r <= cidx_nxt;
    out_status <= os_nxt;
    out_result_index <= oi_nxt;
    out_x <= ox_nxt;
    out_y <= oy_nxt;
    out_z <= oz_nxt;
    out_parent <= op_nxt;
    out_label <= ol_nxt;
    out_last <= olast_nxt;
  end

  assign out_node_count = 7'(count_r);

  `CHK_IMPL(a_count_max, clk, rst_n, 1'b1, count_r <= CW'(MAX_NODES))
  `CHK_NEXT(a_busy_after_start, clk, rst_n, start && !busy && in_mode == MD_NEAREST && count_r != '0, busy)
  `CHK_IMPL(a_last_idle, clk, rst_n, out_valid && out_last && state_r != S_IDLE, state_r == S_EMIT || state_r == S_WALK)
endmodule

/* sim/tb_rrt_node_store_nearest_search.sv */
module tb_rrt_node_store_nearest_search
  import rrtns_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [CUT_W-1:0] CUTOFF_MAX = {CUT_W{1'b1}};

  typedef struct {
    status_t            status;
    logic [5:0]         idx;
    logic signed [15:0] x, y, z;
    logic [5:0]         par, lab;
    logic [6:0]         cnt;
    logic               last;
  } node_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_mode = '0;
  logic [5:0] in_node_index = '0;
  logic signed [15:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [5:0] in_parent_index = '0, in_node_label = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CUT_W-1:0] cfg_cutoff_sq = '0;
  logic out_valid;
  logic [2:0] out_status;
  logic [5:0] out_result_index, out_parent, out_label;
  logic signed [15:0] out_x, out_y, out_z;
  logic [6:0] out_node_count;
  logic out_last;

  rrt_node_store_nearest_search DUT (
    .clk, .rst_n, .start, .busy, .in_mode, .in_node_index, .in_pos_x, .in_pos_y,
    .in_pos_z, .in_parent_index, .in_node_label, .cfg_valid, .cfg_ready,
    .cfg_cutoff_sq, .out_valid, .out_status, .out_result_index, .out_x, .out_y,
    .out_z, .out_parent, .out_label, .out_node_count, .out_last
  );

  // tree shadow
  logic signed [15:0] tree_x[NODES], tree_y[NODES], tree_z[NODES];
  logic [5:0] tree_par[NODES], tree_lab[NODES];
  int unsigned tree_count;
  logic [CUT_W-1:0] cutoff;

  node_result_t pending_results[$];
  int unsigned idle_pct;
  int unsigned errors, items_sent, results_seen, cycles;

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $realtime);
      $display("FAIL rrt_node_store_nearest_search");
      $finish;
    end
  end

  function automatic void push_result(status_t st, logic [5:0] idx,
      logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z,
      logic [5:0] par, logic [5:0] lab, logic last);
    node_result_t r;
    r.status = st; r.idx = idx; r.x = x; r.y = y; r.z = z;
    r.par = par; r.lab = lab; r.cnt = tree_count[6:0]; r.last = last;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic longint sq(logic signed [15:0] a, logic signed [15:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  function automatic void predict_tree_op(mode_t m, logic [5:0] ni,
      logic signed [15:0] px, logic signed [15:0] py, logic signed [15:0] pz,
      logic [5:0] pi, logic [5:0] lab);
    longint best, d;
    int unsigned bi, len, cur;
    bit found;
    int unsigned walk[NODES];
    logic signed [15:0] rx, ry, rz;
    logic [5:0] rp, rl;
    case (m)
      MD_ADD: begin
        if (tree_count >= NODES) push_result(ST_FULL, 0, 0, 0, 0, 0, 0, 1'b1);
        else begin
          tree_x[tree_count] = px; tree_y[tree_count] = py; tree_z[tree_count] = pz;
          tree_par[tree_count] = pi; tree_lab[tree_count] = lab;
          tree_count++;
          push_result(ST_OK, 6'(tree_count - 1), 0, 0, 0, 0, 0, 1'b1);
        end
        return;
      end
      MD_CLEAR: begin
        tree_x[0] = px; tree_y[0] = py; tree_z[0] = pz;
        tree_par[0] = 0; tree_lab[0] = 0; tree_count = 1;
        push_result(ST_OK, 0, 0, 0, 0, 0, 0, 1'b1);
        return;
      end
      MD_NEAREST: begin
        best = longint'(cutoff); bi = 0; found = 0;
        for (int i = 0; i < tree_count; i++) begin
          d = sq(px, tree_x[i]) + sq(py, tree_y[i]) + sq(pz, tree_z[i]);
          if (d < best) begin best = d; bi = i; found = 1; end
        end
        push_result(found ? ST_OK : ST_NONE, 6'(bi), 0, 0, 0, 0, 0, 1'b1);
        return;
      end
      default: ;
    endcase
    if (ni >= tree_count) begin
      push_result(ST_BADIDX, 0, 0, 0, 0, 0, 0, 1'b1);
      return;
    end
    case (m)
      MD_REMOVE: begin
        rx = tree_x[ni]; ry = tree_y[ni]; rz = tree_z[ni];
        rp = tree_par[ni]; rl = tree_lab[ni];
        for (int i = ni; i + 1 < tree_count; i++) begin
          tree_x[i] = tree_x[i+1]; tree_y[i] = tree_y[i+1]; tree_z[i] = tree_z[i+1];
          tree_par[i] = tree_par[i+1]; tree_lab[i] = tree_lab[i+1];
        end
        tree_count--;
        push_result(ST_OK, 0, rx, ry, rz, rp, rl, 1'b1);
      end
      MD_READ:
        push_result(ST_OK, 0, tree_x[ni], tree_y[ni], tree_z[ni], tree_par[ni],
                    tree_lab[ni], 1'b1);
      MD_SETPOS: begin
        tree_x[ni] = px; tree_y[ni] = py; tree_z[ni] = pz;
        push_result(ST_OK, 0, 0, 0, 0, 0, 0, 1'b1);
      end
      MD_SETPAR: begin
        tree_par[ni] = pi;
        push_result(ST_OK, 0, 0, 0, 0, 0, 0, 1'b1);
      end
      default: begin
        len = 0; cur = ni;
        forever begin
          if (len >= tree_count) begin
            push_result(ST_CYCLE, 0, 0, 0, 0, 0, 0, 1'b1);
            return;
          end
          walk[len++] = cur;
          if (tree_lab[cur] == 0) break;
          cur = tree_par[cur];
          if (cur >= tree_count) begin
            push_result(ST_BADIDX, 0, 0, 0, 0, 0, 0, 1'b1);
            return;
          end
        end
        for (int k = 0; k < len; k++)
          push_result(ST_OK, 6'(walk[len-1-k]), 0, 0, 0, 0, 0, k + 1 == len);
      end
    endcase
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    node_result_t e;
    if (rst_n && out_valid !== 1'b0) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual status %0d idx %0d",
                 $realtime, out_status, out_result_index);
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, out_status);
        check_field("result_index", e.idx, out_result_index);
        check_field("x", e.x, out_x);
        check_field("y", e.y, out_y);
        check_field("z", e.z, out_z);
        check_field("parent", e.par, out_parent);
        check_field("label", e.lab, out_label);
        check_field("node_count", e.cnt, out_node_count);
        check_field("last", e.last, out_last);
      end
    end
  end

  task automatic send_op(mode_t m, logic [5:0] ni, logic signed [15:0] px,
      logic signed [15:0] py, logic signed [15:0] pz, logic [5:0] pi, logic [5:0] lab);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= m; in_node_index <= ni; in_pos_x <= px; in_pos_y <= py;
    in_pos_z <= pz; in_parent_index <= pi; in_node_label <= lab;
    do @(posedge clk); while (busy !== 1'b0);
    predict_tree_op(m, ni, px, py, pz, pi, lab);
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cutoff(logic [CUT_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_cutoff_sq <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cutoff = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [5:0] pick_index();
    if (tree_count > 0 && $urandom_range(99) < 85) return 6'($urandom_range(tree_count - 1));
    return 6'($urandom_range(63));
  endfunction

  task automatic test_directed();
    send_op(MD_READ, 0, 0, 0, 0, 0, 0);
    send_op(MD_ADD, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 6'd63);
    send_op(MD_ADD, 0, -16'sh8000, -16'sh8000, -16'sh8000, 6'd1, 6'd1);
    send_op(MD_READ, 2, 0, 0, 0, 0, 0);
    send_op(MD_NEAREST, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0);
    send_op(MD_NEAREST, 0, -16'sh8000, -16'sh8000, -16'sh8000, 0, 0);
    send_op(MD_PATH, 1, 0, 0, 0, 0, 0);
    send_op(MD_SETPAR, 1, 0, 0, 0, 6'd2, 0);
    send_op(MD_PATH, 2, 0, 0, 0, 0, 0);     // loops through node 1 and 2
    send_op(MD_SETPAR, 2, 0, 0, 0, 6'd0, 0);
    send_op(MD_PATH, 2, 0, 0, 0, 0, 0);
    send_op(MD_SETPAR, 1, 0, 0, 0, 6'd40, 0);
    send_op(MD_PATH, 1, 0, 0, 0, 0, 0);     // parent off the table
    send_op(MD_SETPOS, 1, 16'sh0010, -16'sh0020, 16'sh0030, 0, 0);
    send_op(MD_READ, 63, 0, 0, 0, 0, 0);
    send_op(MD_REMOVE, 3, 0, 0, 0, 0, 0);
    send_op(MD_SETPOS, 9, 0, 0, 0, 0, 0);
    send_op(MD_SETPAR, 9, 0, 0, 0, 0, 0);
    send_op(MD_PATH, 9, 0, 0, 0, 0, 0);
    send_op(MD_REMOVE, 0, 0, 0, 0, 0, 0);
    send_op(MD_REMOVE, 1, 0, 0, 0, 0, 0);
    send_op(MD_REMOVE, 0, 0, 0, 0, 0, 0);   // table now empty
    send_op(MD_NEAREST, 0, 0, 0, 0, 0, 0);
    send_op(MD_PATH, 0, 0, 0, 0, 0, 0);
    send_op(MD_ADD, 0, 16'sh0100, 0, 0, 6'd5, 6'd0);
    send_op(MD_CLEAR, 0, -16'sh0005, 16'sh0007, 0, 0, 0);
  endtask

  // chain every node to the previous one so the deepest path covers the table
  task automatic test_fill_table();
    send_op(MD_CLEAR, 0, 16'($urandom), 16'($urandom), 16'($urandom), 0, 0);
    for (int i = 1; i < NODES + 2; i++)
      send_op(MD_ADD, 0, 16'($urandom), 16'($urandom), 16'($urandom),
              6'(i - 1), 6'($urandom_range(1, 63)));
    send_op(MD_PATH, 6'(NODES - 1), 0, 0, 0, 0, 0);
    send_op(MD_NEAREST, 0, tree_x[NODES-1], tree_y[NODES-1], tree_z[NODES-1], 0, 0);
    send_op(MD_SETPAR, 0, 0, 0, 0, 6'(NODES - 1), 0);
    send_op(MD_SETPOS, 6'(NODES - 1), 16'($urandom), 16'($urandom), 16'($urandom), 0, 0);
    send_op(MD_REMOVE, 6'(NODES - 1), 0, 0, 0, 0, 0);
    send_op(MD_REMOVE, 0, 0, 0, 0, 0, 0);
    send_op(MD_PATH, 6'(NODES - 3), 0, 0, 0, 0, 0);
  endtask

  task automatic test_random(int n);
    int unsigned r, j;
    logic signed [15:0] px, py, pz;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      px = 16'($urandom); py = 16'($urandom); pz = 16'($urandom);
      if (r < 25)
        send_op(MD_ADD, 6'($urandom), px, py, pz,
                $urandom_range(3) == 0 ? 6'($urandom) : pick_index(),
                $urandom_range(4) == 0 ? 6'd0 : 6'($urandom));
      else if (r < 33) send_op(MD_REMOVE, pick_index(), px, py, pz, 0, 0);
      else if (r < 43) send_op(MD_READ, pick_index(), px, py, pz, 0, 0);
      else if (r < 50) send_op(MD_SETPOS, pick_index(), px, py, pz, 0, 0);
      else if (r < 58)
        send_op(MD_SETPAR, pick_index(), px, py, pz,
                $urandom_range(3) == 0 ? 6'($urandom) : pick_index(), 0);
      else if (r < 78) begin
        if (tree_count > 0 && $urandom_range(1)) begin
          j = $urandom_range(tree_count - 1);
          px = tree_x[j] + 16'($signed(5'($urandom)));
          py = tree_y[j] + 16'($signed(5'($urandom)));
          pz = tree_z[j] + 16'($signed(5'($urandom)));
        end
        send_op(MD_NEAREST, 6'($urandom), px, py, pz, 0, 0);
      end else if (r < 95) send_op(MD_PATH, pick_index(), px, py, pz, 0, 0);
      else send_op(MD_CLEAR, 6'($urandom), px, py, pz, 0, 0);
    end
  endtask

  initial begin
    tree_count = 1;
    cutoff = CUTOFF_RESET;
    for (int i = 0; i < NODES; i++) begin
      tree_x[i] = 0; tree_y[i] = 0; tree_z[i] = 0; tree_par[i] = 0; tree_lab[i] = 0;
    end
    idle_pct = 37;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    set_cutoff('0);
    test_random(15);
    set_cutoff(CUTOFF_MAX);
    test_fill_table();
    idle_pct = 54;
    set_cutoff(34'd200);
    test_random(60);
    set_cutoff(34'($urandom_range(1000000)) * 34'd1000);
    test_random(50);
    idle_pct = 0;
    set_cutoff(CUTOFF_RESET);
    test_random(46);

    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t %0d expected results never arrived", $realtime, pending_results.size());
    end
    $display("Covered %0d items and %0d results over all operations, a full table,",
             items_sent, results_seen);
    $display("an empty table, long paths, cycles and five cutoff settings.");
    if (errors == 0) $display("PASS rrt_node_store_nearest_search");
    else $display("FAIL rrt_node_store_nearest_search");
    $finish;
  end
endmodule
